// File: sv/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
package swm_pkg;

    // Width of the window size register.
    localparam int CFG_BITS = 7;

    // Per-word controls broadcast from the top level to every sorted cell.
    typedef struct packed {
        logic step;        // word accepted this cycle
        logic flush;       // window treated as empty before this word goes in
        logic wipe;        // config write: drop all held samples
        logic rm_en;       // window full after insert: drop the oldest sample
        logic new_ge_old;  // incoming sample >= oldest sample
    } t_cell_ctl;

endpackage

// File: sv/swm_cell.sv
// One cell of the sorted row: holds one sorted sample and one arrival tap.
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_old,
    // left neighbor (lower sorted position, newer arrival tap)
    input  logic signed [SAMPLE_BITS-1:0] i_left_val,
    input  logic                          i_left_gt,
    input  logic                          i_left_vld,
    input  logic                          i_left_ge,
    input  logic signed [SAMPLE_BITS-1:0] i_left_arr,
    // right neighbor, after insertion
    input  logic signed [SAMPLE_BITS-1:0] i_right_ins_val,
    input  logic                          i_right_ins_vld,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic                          o_vld_eff,
    output logic                          o_gt,
    output logic                          o_ge,
    output logic signed [SAMPLE_BITS-1:0] o_arr,
    output logic signed [SAMPLE_BITS-1:0] o_ins_val,
    output logic                          o_ins_vld,
    output logic                          o_vld
);

    logic signed [SAMPLE_BITS-1:0] r_val;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic signed [SAMPLE_BITS-1:0] r_arr;
    logic                          r_vld;
    logic                          n_vld;
    logic                          vld_eff;
    logic                          gt;
    logic                          ge;
    logic signed [SAMPLE_BITS-1:0] ins_val;
    logic                          ins_ge;
    logic                          ins_vld;
    logic                          rm;

    assign vld_eff = r_vld & ~i_ctl.flush;
    // empty cells sort above everything
    assign gt      = ~vld_eff | (r_val > i_sample);
    assign ge      = (r_val >= i_old);

    always_comb begin
        if (!gt) begin
            ins_val = r_val;
            ins_ge  = ge;
        end else if (i_left_gt) begin
            ins_val = i_left_val;
            ins_ge  = i_left_ge;
        end else begin
            ins_val = i_sample;
            ins_ge  = i_ctl.new_ge_old;
        end
    end

    assign ins_vld = i_left_vld;
    // sorted: every position at or past the leaving sample pulls from the right
    assign rm      = i_ctl.rm_en & ins_vld & ins_ge;

    always_comb begin
        if (rm) begin
            n_val = i_right_ins_val;
            n_vld = i_right_ins_vld;
        end else begin
            n_val = ins_val;
            n_vld = ins_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.wipe) begin
            r_vld <= 1'b0;
        end else if (i_ctl.step) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_val <= n_val;
            r_arr <= i_left_arr;
        end
    end

    assign o_val     = r_val;
    assign o_vld_eff = vld_eff;
    assign o_gt      = gt;
    assign o_ge      = ge;
    assign o_arr     = r_arr;
    assign o_ins_val = ins_val;
    assign o_ins_vld = ins_vld;
    assign o_vld     = r_vld;

endmodule

// File: sv/sliding_window_median.sv
// Sliding-window median filter: top level with the cell row and output pipeline.
//
// Input channel: i_in_valid / o_in_stall carry i_sample (signed) and i_restart.
// A word is taken at a clock edge with i_in_valid high and o_in_stall low.
// i_restart empties the window before its sample goes in.
// Output channel: o_out_valid / i_out_stall carry o_median_twice, the window
// median times two (one fractional bit). A result appears once the window holds
// window_size samples, and for every sample after that until the next restart.
// Config: i_cfg_we writes i_cfg_wdata as the window size (0 acts as 1, sizes
// above WINDOW_MAX act as WINDOW_MAX) and empties the window. Write it idle only.
// Throughput: one sample per clock while o_in_stall is low. The row of WINDOW_MAX
// cells inserts the new sample and drops the oldest in the same cycle; each cell
// compares its value against the new and the oldest sample.
// Pipeline: a taken sample's result passes the median select register, then is
// summed into the output register.
// Reset: window size 1, window empty, output empty.
// Stall: the two output stages hold their words; o_in_stall rises only when
// both are full and i_out_stall is high.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_BITS-1:0]           i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS:0]   o_median_twice
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int OB = SAMPLE_BITS + 1;

    logic [CFG_BITS-1:0]           r_ws;
    logic [KW-1:0]                 r_fill;
    logic [KW-1:0]                 n_fill;
    logic [KW-1:0]                 keff;
    logic [KW-1:0]                 keff_m2;
    logic [KW-1:0]                 half;
    logic [KW-1:0]                 fill_eff;
    logic [IW-1:0]                 old_idx;
    logic [IW-1:0]                 idx_a;
    logic [IW-1:0]                 idx_b;
    logic                          in_acc;
    logic                          flush;
    logic                          emit;
    logic signed [SAMPLE_BITS-1:0] old_val;
    t_cell_ctl                     ctl;

    logic signed [SAMPLE_BITS-1:0] w_val     [WINDOW_MAX];
    logic                          w_vld_eff [WINDOW_MAX];
    logic                          w_gt      [WINDOW_MAX];
    logic                          w_ge      [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_arr     [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_ins_val [WINDOW_MAX];
    logic                          w_ins_vld [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         w_vld;

    logic signed [SAMPLE_BITS-1:0] l_val     [WINDOW_MAX];
    logic                          l_gt      [WINDOW_MAX];
    logic                          l_vld     [WINDOW_MAX];
    logic                          l_ge      [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] l_arr     [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] rt_val    [WINDOW_MAX];
    logic                          rt_vld    [WINDOW_MAX];

    logic                          r_p1_vld;
    logic signed [SAMPLE_BITS-1:0] r_med_a;
    logic signed [SAMPLE_BITS-1:0] r_med_b;
    logic                          r_out_vld;
    logic signed [OB-1:0]          r_out;
    logic                          out_free;
    logic                          p1_free;

    // effective window size
    always_comb begin
        if (r_ws == '0) begin
            keff = KW'(1);
        end else if (int'(r_ws) > WINDOW_MAX) begin
            keff = KW'(WINDOW_MAX);
        end else begin
            keff = KW'(r_ws);
        end
    end

    assign in_acc   = i_in_valid & ~o_in_stall;
    assign flush    = i_restart | (r_fill >= keff);
    assign fill_eff = flush ? '0 : r_fill;
    assign emit     = ((fill_eff + KW'(1)) == keff);
    assign n_fill   = emit ? fill_eff : fill_eff + KW'(1);

    // oldest sample in the window once this word is in: arrival tap keff-2
    assign keff_m2  = keff - KW'(2);
    assign old_idx  = keff_m2[IW-1:0];
    assign old_val  = (keff == KW'(1)) ? i_sample : w_arr[old_idx];

    assign ctl.step       = in_acc;
    assign ctl.flush      = flush;
    assign ctl.wipe       = i_cfg_we;
    assign ctl.rm_en      = emit;
    assign ctl.new_ge_old = (i_sample >= old_val);

    // neighbor wiring of the cell row
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (i == 0) begin
                l_val[i] = i_sample;
                l_gt[i]  = 1'b0;
                l_vld[i] = 1'b1;
                l_ge[i]  = ctl.new_ge_old;
                l_arr[i] = i_sample;
            end else begin
                l_val[i] = w_val[i-1];
                l_gt[i]  = w_gt[i-1];
                l_vld[i] = w_vld_eff[i-1];
                l_ge[i]  = w_ge[i-1];
                l_arr[i] = w_arr[i-1];
            end
            if (i == WINDOW_MAX - 1) begin
                rt_val[i] = '0;
                rt_vld[i] = 1'b0;
            end else begin
                rt_val[i] = w_ins_val[i+1];
                rt_vld[i] = w_ins_vld[i+1];
            end
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_sample       (i_sample),
            .i_old          (old_val),
            .i_left_val     (l_val[g]),
            .i_left_gt      (l_gt[g]),
            .i_left_vld     (l_vld[g]),
            .i_left_ge      (l_ge[g]),
            .i_left_arr     (l_arr[g]),
            .i_right_ins_val(rt_val[g]),
            .i_right_ins_vld(rt_vld[g]),
            .o_val          (w_val[g]),
            .o_vld_eff      (w_vld_eff[g]),
            .o_gt           (w_gt[g]),
            .o_ge           (w_ge[g]),
            .o_arr          (w_arr[g]),
            .o_ins_val      (w_ins_val[g]),
            .o_ins_vld      (w_ins_vld[g]),
            .o_vld          (w_vld[g])
        );
    end

    // middle positions of the sorted row after insertion
    assign half  = keff >> 1;
    assign idx_b = half[IW-1:0];
    assign idx_a = keff[0] ? idx_b : idx_b - IW'(1);

    assign out_free   = ~r_out_vld | ~i_out_stall;
    assign p1_free    = ~r_p1_vld | out_free;
    assign o_in_stall = ~p1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= CFG_BITS'(1);
            r_fill    <= '0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws   <= i_cfg_wdata;
                r_fill <= '0;
            end else if (in_acc) begin
                r_fill <= n_fill;
            end
            if (out_free) begin
                r_out_vld <= r_p1_vld;
            end
            if (p1_free) begin
                r_p1_vld <= in_acc & emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_free && in_acc && emit) begin
            r_med_a <= w_ins_val[idx_a];
            r_med_b <= w_ins_val[idx_b];
        end
        if (out_free && r_p1_vld) begin
            r_out <= {r_med_a[SAMPLE_BITS-1], r_med_a} + {r_med_b[SAMPLE_BITS-1], r_med_b};
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_median_twice = r_out;

    a_fill_below_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < keff)
        else $error("fill count reached window size");

    a_cells_match_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == int'(r_fill))
        else $error("held cells disagree with fill count");

    a_emit_loads_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit) |=> r_p1_vld)
        else $error("result word lost at median select stage");

endmodule
